@@ design/adb_scancode_to_hid_key_tracker_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ADB_SCANCODE_TO_HID_KEY_TRACKER_MACROS_SVH
`define ADB_SCANCODE_TO_HID_KEY_TRACKER_MACROS_SVH

// Checked only while out of reset.
`define ADBHID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: check failed");

// Checked at every edge, reset included.
`define ADBHID_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("%m: check failed");

`endif

@@ design/adbhid_pkg.sv @@
package adbhid_pkg;

    localparam int CODE_W     = 8;
    localparam int KEY_W      = 8;
    localparam int MOD_W      = 5;
    localparam int SLOT_MAX   = 6;
    localparam int HELD_SLOTS = 6;
    localparam int NSLOT      = (HELD_SLOTS < 1) ? 1 :
                                ((HELD_SLOTS > SLOT_MAX) ? SLOT_MAX : HELD_SLOTS);

    localparam logic [CODE_W-1:0] IDLE_CODE = 8'hFF;

    // ADB key numbers of the modifier keys
    localparam logic [6:0] ADB_LCTRL  = 7'h36;
    localparam logic [6:0] ADB_LGUI   = 7'h37;
    localparam logic [6:0] ADB_LSHIFT = 7'h38;
    localparam logic [6:0] ADB_LALT   = 7'h3A;
    localparam logic [6:0] ADB_RSHIFT = 7'h7B;

    // Bit positions in the modifier flags
    localparam int MOD_LCTRL  = 0;
    localparam int MOD_LSHIFT = 1;
    localparam int MOD_LALT   = 2;
    localparam int MOD_LGUI   = 3;
    localparam int MOD_RSHIFT = 4;

    typedef logic [SLOT_MAX-1:0][KEY_W-1:0] held_list_t;

    typedef struct packed {
        logic [MOD_W-1:0] mods;
        held_list_t       held;
    } key_state_t;

    localparam logic [KEY_W-1:0] ADB_TO_HID [128] = '{
        8'h04, 8'h16, 8'h07, 8'h09, 8'h0B, 8'h0A, 8'h1D, 8'h1B,
        8'h06, 8'h19, 8'h00, 8'h05, 8'h14, 8'h1A, 8'h08, 8'h15,
        8'h1C, 8'h17, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h23, 8'h22,
        8'h2E, 8'h26, 8'h24, 8'h2D, 8'h25, 8'h27, 8'h30, 8'h12,
        8'h18, 8'h2F, 8'h0C, 8'h13, 8'h28, 8'h0F, 8'h0D, 8'h34,
        8'h0E, 8'h33, 8'h31, 8'h36, 8'h38, 8'h11, 8'h10, 8'h37,
        8'h2B, 8'h2C, 8'h35, 8'h2A, 8'h00, 8'h29, 8'h00, 8'h00,
        8'h00, 8'h39, 8'h00, 8'h50, 8'h4F, 8'h51, 8'h52, 8'h00,
        8'h00, 8'h63, 8'h00, 8'h55, 8'h00, 8'h57, 8'h00, 8'h53,
        8'h00, 8'h00, 8'h00, 8'h54, 8'h58, 8'h00, 8'h56, 8'h00,
        8'h00, 8'h00, 8'h62, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D,
        8'h5E, 8'h5F, 8'h00, 8'h60, 8'h61, 8'h00, 8'h00, 8'h00,
        8'h3E, 8'h3F, 8'h40, 8'h3C, 8'h41, 8'h42, 8'h00, 8'h44,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h43, 8'h00, 8'h45,
        8'h00, 8'h00, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h3D, 8'h4D,
        8'h3B, 8'h4E, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // HID modifier byte: bit 5 carries right shift
    function automatic logic [7:0] hid_modifier_byte(input logic [MOD_W-1:0] mods);
        return {2'b00, mods[MOD_RSHIFT], 1'b0, mods[MOD_LGUI:MOD_LCTRL]};
    endfunction

endpackage

@@ design/adbhid_key_update.sv @@
module adbhid_key_update (
    input  logic [adbhid_pkg::CODE_W-1:0] scan_code,
    input  adbhid_pkg::key_state_t        cur,
    output adbhid_pkg::key_state_t        nxt
);
    import adbhid_pkg::*;

    logic [6:0]        key;
    logic              release_evt;
    logic [KEY_W-1:0]  usage;
    logic [MOD_W-1:0]  mod_sel;
    logic [NSLOT-1:0]  match;
    logic [NSLOT-1:0]  at_or_after;
    logic              seen;
    held_list_t        pushed;
    held_list_t        pulled;
    held_list_t        compacted;

    always_comb begin
        key         = scan_code[6:0];
        release_evt = scan_code[7];
        usage       = ADB_TO_HID[key];

        mod_sel = '0;
        unique case (key)
            ADB_LCTRL:  mod_sel[MOD_LCTRL]  = 1'b1;
            ADB_LSHIFT: mod_sel[MOD_LSHIFT] = 1'b1;
            ADB_LALT:   mod_sel[MOD_LALT]   = 1'b1;
            ADB_LGUI:   mod_sel[MOD_LGUI]   = 1'b1;
            ADB_RSHIFT: mod_sel[MOD_RSHIFT] = 1'b1;
            default:    mod_sel = '0;
        endcase

        // Compare all live slots at once; mark every slot from the hit onward
        seen = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            match[i]       = (cur.held[i] == usage);
            seen           = seen | match[i];
            at_or_after[i] = seen;
        end

        // Press: shift toward oldest, drop slots past the live count
        pushed    = held_list_t'(cur.held << KEY_W);
        pushed[0] = usage;
        for (int i = NSLOT; i < SLOT_MAX; i++) begin
            pushed[i] = '0;
        end

        // Release: slots past the live count are zero, so the top fills with zero
        pulled    = held_list_t'(cur.held >> KEY_W);
        compacted = cur.held;
        for (int i = 0; i < NSLOT; i++) begin
            if (at_or_after[i]) begin
                compacted[i] = pulled[i];
            end
        end

        nxt = cur;
        priority if (scan_code == IDLE_CODE) begin
            nxt = cur;
        end else if (mod_sel != '0) begin
            nxt.mods = release_evt ? (cur.mods & ~mod_sel) : (cur.mods | mod_sel);
        end else if (usage == '0) begin
            nxt = cur;
        end else if (release_evt) begin
            if (seen) begin
                nxt.held = compacted;
            end
        end else begin
            if (!seen) begin
                nxt.held = pushed;
            end
        end
    end

endmodule

@@ design/adb_scancode_to_hid_key_tracker.sv @@
// ADB scan code to HID key tracker.
// Input channel (s_valid/s_ready/s_scan_code): one ADB code byte per
// transaction; bit 7 marks a release, bits 6..0 the key, 0xFF is idle.
// Result channel (m_valid/m_ready/m_*): one transaction per input code,
// carrying the HID modifier byte and six held-key slots, newest first,
// zero where a slot is empty.
// Latency: the result is valid the cycle after the input is accepted.
// Throughput: one code per cycle while the receiver takes each result;
// the slot compare and one-level list shift are combinational.
// Stall: while a result waits unaccepted, s_ready is low and the result
// holds; the result register frees in the same cycle it is taken, so the
// next code can be accepted at that edge.
// Reset (aresetn low, synchronous): the key list and modifier flags clear
// and no result is pending.
module adb_scancode_to_hid_key_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [adbhid_pkg::CODE_W-1:0] s_scan_code,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_modifier_bits,
    output logic [adbhid_pkg::KEY_W-1:0]  m_held_key_0,
    output logic [adbhid_pkg::KEY_W-1:0]  m_held_key_1,
    output logic [adbhid_pkg::KEY_W-1:0]  m_held_key_2,
    output logic [adbhid_pkg::KEY_W-1:0]  m_held_key_3,
    output logic [adbhid_pkg::KEY_W-1:0]  m_held_key_4,
    output logic [adbhid_pkg::KEY_W-1:0]  m_held_key_5
);
    import adbhid_pkg::*;

    key_state_t state_reg;
    key_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       in_fire;

    adbhid_key_update u_update (
        .scan_code (s_scan_code),
        .cur       (state_reg),
        .nxt       (state_next)
    );

    // Result register doubles as the tracker state: advance only when free
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (in_fire) begin
                state_reg <= state_next;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_modifier_bits = hid_modifier_byte(state_reg.mods);
    assign m_held_key_0    = state_reg.held[0];
    assign m_held_key_1    = state_reg.held[1];
    assign m_held_key_2    = state_reg.held[2];
    assign m_held_key_3    = state_reg.held[3];
    assign m_held_key_4    = state_reg.held[4];
    assign m_held_key_5    = state_reg.held[5];

endmodule

@@ design/adbhid_checker.sv @@
`include "adb_scancode_to_hid_key_tracker_macros.svh"

module adbhid_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [adbhid_pkg::CODE_W-1:0] s_scan_code,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [7:0]                    m_modifier_bits,
    input logic [adbhid_pkg::KEY_W-1:0]  m_held_key_0,
    input logic [adbhid_pkg::KEY_W-1:0]  m_held_key_1,
    input logic [adbhid_pkg::KEY_W-1:0]  m_held_key_2,
    input logic [adbhid_pkg::KEY_W-1:0]  m_held_key_3,
    input logic [adbhid_pkg::KEY_W-1:0]  m_held_key_4,
    input logic [adbhid_pkg::KEY_W-1:0]  m_held_key_5
);
    import adbhid_pkg::*;

    logic unused_code;
    assign unused_code = ^s_scan_code;

    // No result pending right after reset
    `ADBHID_ASSERT_ALWAYS(a_reset_idle, !$past(aresetn) |-> !m_valid)

    // Unused modifier bits stay clear
    `ADBHID_ASSERT(a_mod_spare_zero,
        m_valid |-> (m_modifier_bits[7:6] == 2'b00 && m_modifier_bits[4] == 1'b0))

    // Hold off input while a result is stalled
    `ADBHID_ASSERT(a_stall_blocks_input, (m_valid && !m_ready) |-> !s_ready)

    // Every accepted code yields a result on the next cycle
    `ADBHID_ASSERT(a_accept_gives_result, (s_valid && s_ready) |=> m_valid)

    // A stalled result holds its modifier byte and first and last held-key slots
    `ADBHID_ASSERT(a_stall_holds_payload,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_modifier_bits)
            && $stable(m_held_key_0) && $stable(m_held_key_5)))

endmodule

bind adb_scancode_to_hid_key_tracker adbhid_checker u_adbhid_checker (.*);
